@@ sv/tsi_pkg.sv @@
// Shared types and constants for the trace segment intercept unit.
`timescale 1ns / 1ps

package tsi_pkg;

    // Long division steps: the quotient magnitude stays below 2^30 once saturation is excluded
    localparam int DIV_STEPS = 30;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_Y  = 3'd3;

    localparam logic [31:0] FRAC_MIN = 32'h8000_0000;
    localparam logic [31:0] FRAC_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] seg_start_x;
        logic signed [31:0] seg_start_y;
        logic signed [31:0] seg_end_x;
        logic signed [31:0] seg_end_y;
    } t_seg_item;

    typedef struct packed {
        logic               start_behind;
        logic               end_behind;
        logic               crossed;
        logic               parallel;
        logic signed [31:0] fraction;
        logic               hit;
    } t_res_item;

    // Endpoint side test, first half: either settled early or left to the product compare
    typedef struct packed {
        logic        decided;
        logic        side;
        logic [23:0] dxh;
        logic [23:0] dyh;
    } t_side_pre;

    // Flags that ride along with the divider
    typedef struct packed {
        logic s1;
        logic s2;
        logic crossed;
        logic par;
        logic sat;
        logic neg;
    } t_dv_flags;

endpackage

@@ sv/trace_segment_intercept_unit.sv @@
// Trace segment intercept unit: side test and intercept fraction, fully pipelined.
// Usage:
//   Configure the trace (origin x/y, delta x/y, signed 16.16) through the write
//   port i_cfg_we / i_cfg_idx / i_cfg_data while no transaction is in flight.
//   Indexes beyond the four trace registers are ignored.
//   Input channel: i_in_valid / o_in_stall carry one segment (two endpoints).
//   Output channel: o_out_valid / i_out_stall carry one result per segment, in
//   order: endpoint sides, crossed, parallel, 16.16 fraction and hit.
// Pipeline:
//   Stages A to D do the side test, products and sums; a restoring divider
//   follows (one quotient bit per stage), then one output register. One
//   transaction enters per cycle while the pipeline is not stalled.
// Flow control:
//   The whole pipeline advances together. When the output register holds a
//   result and i_out_stall is high, every stage holds and o_in_stall is high;
//   otherwise a new transaction is accepted every cycle.
// Reset:
//   Synchronous, active low. Clears all valid bits and the trace registers.
`timescale 1ns / 1ps

module trace_segment_intercept_unit
    import tsi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_seg_item            i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_res_item            o_out_item
);

    logic [31:0] r_org_x, r_org_y, r_dlt_x, r_dlt_y;

    logic w_en;

    // stage A: differences and early side decisions
    logic        r_a_vld;
    t_side_pre   r_a_p1, r_a_p2;
    logic [31:0] r_a_sdx, r_a_sdy;
    logic [23:0] r_a_nyh;

    // stage B: products
    logic        r_b_vld;
    logic [1:0]  r_b_dec, r_b_side;
    logic [31:0] r_b_p1a, r_b_p1b, r_b_p2a, r_b_p2b;
    logic [31:0] r_b_dna, r_b_dnb, r_b_nma, r_b_nmb;

    // stage C: sides, denominator, numerator
    logic        r_c_vld;
    logic        r_c_s1, r_c_s2;
    logic [31:0] r_c_den, r_c_num;

    // stage D: magnitudes, divider setup
    logic        r_d_vld;
    logic [31:0] r_d_rem, r_d_mb;
    logic [29:0] r_d_lo;
    t_dv_flags   r_d_fl;

    // divider stages
    logic        r_dv_vld [DIV_STEPS];
    logic [31:0] r_dv_rem [DIV_STEPS];
    logic [31:0] r_dv_mb  [DIV_STEPS];
    logic [29:0] r_dv_lo  [DIV_STEPS];
    logic [29:0] r_dv_q   [DIV_STEPS];
    t_dv_flags   r_dv_fl  [DIV_STEPS];

    logic      r_out_vld;
    t_res_item r_out_item;
    t_res_item n_out_item;

    assign w_en        = !(r_out_vld && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_dlt_x <= '0;
            r_dlt_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                CFG_DELTA_X:  r_dlt_x <= i_cfg_data;
                CFG_DELTA_Y:  r_dlt_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic t_side_pre f_side_pre(
        input logic [31:0] x,
        input logic [31:0] y,
        input logic [31:0] ox,
        input logic [31:0] oy,
        input logic [31:0] tdx,
        input logic [31:0] tdy
    );
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] mix;
        t_side_pre   r;
        dx        = x - ox;
        dy        = y - oy;
        mix       = tdy ^ tdx ^ dx ^ dy;
        r.dxh     = dx[31:8];
        r.dyh     = dy[31:8];
        r.decided = 1'b1;
        if (tdx == '0) begin
            // vertical trace (also a zero direction): x alone decides
            r.side = ($signed(x) <= $signed(ox)) ? (!tdy[31] && (tdy != '0)) : tdy[31];
        end else if (tdy == '0) begin
            r.side = ($signed(y) <= $signed(oy)) ? tdx[31] : !tdx[31];
        end else if (mix[31]) begin
            r.side = tdy[31] ^ dx[31];
        end else begin
            r.decided = 1'b0;
            r.side    = 1'b0;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_p1  <= f_side_pre(i_in_item.seg_start_x, i_in_item.seg_start_y,
                                  r_org_x, r_org_y, r_dlt_x, r_dlt_y);
            r_a_p2  <= f_side_pre(i_in_item.seg_end_x, i_in_item.seg_end_y,
                                  r_org_x, r_org_y, r_dlt_x, r_dlt_y);
            r_a_sdx <= i_in_item.seg_end_x - i_in_item.seg_start_x;
            r_a_sdy <= i_in_item.seg_end_y - i_in_item.seg_start_y;
            r_a_nyh <= 24'((r_org_y - i_in_item.seg_start_y) >> 8);
        end
    end

    // stage B: all products in parallel; keep bits [47:16] of each
    logic signed [47:0] w_p1a, w_p1b, w_p2a, w_p2b;
    logic signed [55:0] w_dna, w_dnb, w_nma, w_nmb;

    assign w_p1a = $signed(r_a_p1.dyh) * $signed(r_dlt_x[31:8]);
    assign w_p1b = $signed(r_dlt_y[31:8]) * $signed(r_a_p1.dxh);
    assign w_p2a = $signed(r_a_p2.dyh) * $signed(r_dlt_x[31:8]);
    assign w_p2b = $signed(r_dlt_y[31:8]) * $signed(r_a_p2.dxh);
    assign w_dna = $signed(r_a_sdy[31:8]) * $signed(r_dlt_x);
    assign w_dnb = $signed(r_a_sdx[31:8]) * $signed(r_dlt_y);
    assign w_nma = $signed(r_a_p1.dxh) * $signed(r_a_sdy);
    assign w_nmb = $signed(r_a_nyh) * $signed(r_a_sdx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_dec  <= {r_a_p2.decided, r_a_p1.decided};
            r_b_side <= {r_a_p2.side, r_a_p1.side};
            r_b_p1a  <= w_p1a[47:16];
            r_b_p1b  <= w_p1b[47:16];
            r_b_p2a  <= w_p2a[47:16];
            r_b_p2b  <= w_p2b[47:16];
            r_b_dna  <= w_dna[47:16];
            r_b_dnb  <= w_dnb[47:16];
            r_b_nma  <= w_nma[47:16];
            r_b_nmb  <= w_nmb[47:16];
        end
    end

    // stage C
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_s1  <= r_b_dec[0] ? r_b_side[0] : ($signed(r_b_p1a) >= $signed(r_b_p1b));
            r_c_s2  <= r_b_dec[1] ? r_b_side[1] : ($signed(r_b_p2a) >= $signed(r_b_p2b));
            r_c_den <= r_b_dna - r_b_dnb;
            r_c_num <= r_b_nma + r_b_nmb;
        end
    end

    // stage D: magnitudes (0x80000000 negates to itself, read as 2^31 unsigned)
    logic [31:0] w_ma, w_mb;

    assign w_ma = r_c_num[31] ? (32'd0 - r_c_num) : r_c_num;
    assign w_mb = r_c_den[31] ? (32'd0 - r_c_den) : r_c_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_en) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_rem        <= {14'd0, w_ma[31:14]};
            r_d_lo         <= {w_ma[13:0], 16'd0};
            r_d_mb         <= w_mb;
            r_d_fl.s1      <= r_c_s1;
            r_d_fl.s2      <= r_c_s2;
            r_d_fl.crossed <= r_c_s1 ^ r_c_s2;
            r_d_fl.par     <= (r_c_den == '0);
            r_d_fl.sat     <= ({14'd0, w_ma[31:14]} >= w_mb);
            r_d_fl.neg     <= r_c_num[31] ^ r_c_den[31];
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic        w_vld_in;
        logic [31:0] w_rem_in, w_mb_in;
        logic [29:0] w_lo_in, w_q_in;
        t_dv_flags   w_fl_in;
        logic [32:0] w_trial, w_diff;
        logic        w_ge;
        logic [31:0] n_rem;

        if (k == 0) begin : g_first
            assign w_vld_in = r_d_vld;
            assign w_rem_in = r_d_rem;
            assign w_mb_in  = r_d_mb;
            assign w_lo_in  = r_d_lo;
            assign w_q_in   = '0;
            assign w_fl_in  = r_d_fl;
        end else begin : g_next
            assign w_vld_in = r_dv_vld[k-1];
            assign w_rem_in = r_dv_rem[k-1];
            assign w_mb_in  = r_dv_mb[k-1];
            assign w_lo_in  = r_dv_lo[k-1];
            assign w_q_in   = r_dv_q[k-1];
            assign w_fl_in  = r_dv_fl[k-1];
        end

        assign w_trial = {w_rem_in, w_lo_in[29]};
        assign w_diff  = w_trial - {1'b0, w_mb_in};
        assign w_ge    = (w_trial >= {1'b0, w_mb_in});
        assign n_rem   = w_ge ? w_diff[31:0] : w_trial[31:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rem[k] <= n_rem;
                r_dv_mb[k]  <= w_mb_in;
                r_dv_lo[k]  <= {w_lo_in[28:0], 1'b0};
                r_dv_q[k]   <= {w_q_in[28:0], w_ge};
                r_dv_fl[k]  <= w_fl_in;
            end
        end
    end

    // output stage
    t_dv_flags   w_fl;
    logic [31:0] w_qext;
    logic [31:0] w_frac;

    assign w_fl   = r_dv_fl[DIV_STEPS-1];
    assign w_qext = {2'd0, r_dv_q[DIV_STEPS-1]};

    always_comb begin
        if (!w_fl.crossed || w_fl.par) begin
            w_frac = '0;
        end else if (w_fl.sat) begin
            w_frac = w_fl.neg ? FRAC_MIN : FRAC_MAX;
        end else begin
            w_frac = w_fl.neg ? (32'd0 - w_qext) : w_qext;
        end
        n_out_item.start_behind = w_fl.s1;
        n_out_item.end_behind   = w_fl.s2;
        n_out_item.crossed      = w_fl.crossed;
        n_out_item.parallel     = w_fl.crossed && w_fl.par;
        n_out_item.fraction     = w_frac;
        n_out_item.hit          = w_fl.crossed && !w_frac[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_dv_vld[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

@@ sv/tsi_checker.sv @@
// Port-level checks for the trace segment intercept unit, bound to the top level.
`timescale 1ns / 1ps

module tsi_checker
    import tsi_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_res_item o_out_item
);

    // a stalled result transaction stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("output transaction changed under stall");

    // a full, stalled output backs up the input side
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input accepted while output is blocked");

    a_crossed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_item.crossed == (o_out_item.start_behind ^ o_out_item.end_behind)))
        else $error("crossed does not match endpoint sides");

    a_parallel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.parallel) |->
            (o_out_item.crossed && o_out_item.hit && (o_out_item.fraction == '0)))
        else $error("parallel result is inconsistent");

    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.hit) |->
            (o_out_item.crossed && !o_out_item.fraction[31]))
        else $error("hit without a nonnegative crossing");

endmodule

bind trace_segment_intercept_unit tsi_checker u_tsi_checker (.*);

@@ sim/tb_top.sv @@
// Self-checking testbench for the trace segment intercept unit.
`timescale 1ns / 1ps

module tb_top
    import tsi_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_DELTA_Y + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 244;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_REPORTS     = 10;

    typedef enum logic {ROW_CFG, ROW_SEG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [31:0]            data;
        t_seg_item              seg;
        logic                   typed;
        t_res_item              res;
    } t_dir_row;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [31:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_seg_item            in_item  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_res_item            out_item;

    // trace registers as the block should hold them
    logic [31:0] trace_ox = '0;
    logic [31:0] trace_oy = '0;
    logic [31:0] trace_dx = '0;
    logic [31:0] trace_dy = '0;

    t_res_item expected_results[$];
    t_dir_row  dir_rows[$];
    int        fail_count = 0;
    int        idle_pct   = 0;
    int        stall_pct  = 0;

    trace_segment_intercept_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // ---------------- fixed point predictor ----------------

    function automatic logic [31:0] sra8(logic [31:0] v);
        return $signed(v) >>> 8;
    endfunction

    function automatic logic [31:0] q_mul(logic [31:0] a, logic [31:0] b);
        longint p;
        p = longint'($signed(a)) * longint'($signed(b));
        return 32'(p >>> 16);
    endfunction

    // saturating 16.16 divide
    function automatic logic [31:0] q_div(logic [31:0] a, logic [31:0] b);
        longint sa, sb, ma, mb;
        sa = longint'($signed(a));
        sb = longint'($signed(b));
        ma = (sa < 0) ? -sa : sa;
        mb = (sb < 0) ? -sb : sb;
        if ((ma >>> 14) >= mb)
            return (a[31] ^ b[31]) ? FRAC_MIN : FRAC_MAX;
        return 32'((sa * 65536) / sb);
    endfunction

    function automatic logic endpoint_behind(logic [31:0] x, logic [31:0] y);
        logic [31:0] dx, dy;
        // zero direction falls into the vertical rule
        if (trace_dx == '0)
            return ($signed(x) <= $signed(trace_ox)) ? ($signed(trace_dy) > 0)
                                                     : ($signed(trace_dy) < 0);
        if (trace_dy == '0)
            return ($signed(y) <= $signed(trace_oy)) ? ($signed(trace_dx) < 0)
                                                     : ($signed(trace_dx) > 0);
        dx = x - trace_ox;
        dy = y - trace_oy;
        if (trace_dy[31] ^ trace_dx[31] ^ dx[31] ^ dy[31])
            return trace_dy[31] ^ dx[31];
        return $signed(q_mul(sra8(dy), sra8(trace_dx))) >=
               $signed(q_mul(sra8(trace_dy), sra8(dx)));
    endfunction

    function automatic t_res_item predict_intercept(t_seg_item s);
        t_res_item   r;
        logic [31:0] x1, y1, x2, y2, sdx, sdy, den, num;
        x1 = s.seg_start_x;
        y1 = s.seg_start_y;
        x2 = s.seg_end_x;
        y2 = s.seg_end_y;
        r = '0;
        r.start_behind = endpoint_behind(x1, y1);
        r.end_behind   = endpoint_behind(x2, y2);
        r.crossed      = r.start_behind != r.end_behind;
        if (r.crossed) begin
            sdx = x2 - x1;
            sdy = y2 - y1;
            den = q_mul(sra8(sdy), trace_dx) - q_mul(sra8(sdx), trace_dy);
            if (den == '0) begin
                r.parallel = 1'b1;
            end else begin
                num = q_mul(sra8(x1 - trace_ox), sdy) + q_mul(sra8(trace_oy - y1), sdx);
                r.fraction = q_div(num, den);
            end
            r.hit = ~r.fraction[31];
        end
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [31:0] rand_offset(int unsigned k);
        logic [31:0] v;
        v = $urandom & ((32'd1 << k) - 32'd1);
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    function automatic logic [31:0] rand_fix();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2: return $urandom;
            default: return rand_offset($urandom_range(1, 31));
        endcase
    endfunction

    // mostly segments around the trace origin so crossings are common
    function automatic t_seg_item rand_segment();
        t_seg_item   s;
        int unsigned k;
        k = $urandom_range(4, 30);
        if ($urandom_range(0, 9) == 0) begin
            s.seg_start_x = rand_fix();
            s.seg_start_y = rand_fix();
            s.seg_end_x   = rand_fix();
            s.seg_end_y   = rand_fix();
        end else begin
            s.seg_start_x = trace_ox + rand_offset(k);
            s.seg_start_y = trace_oy + rand_offset(k);
            if ($urandom_range(0, 4) == 0) begin
                // short segment, tends to zero the denominator
                s.seg_end_x = s.seg_start_x + rand_offset($urandom_range(0, 12));
                s.seg_end_y = s.seg_start_y + rand_offset($urandom_range(0, 12));
            end else begin
                s.seg_end_x = trace_ox + rand_offset(k);
                s.seg_end_y = trace_oy + rand_offset(k);
            end
        end
        return s;
    endfunction

    function automatic t_res_item res_val(logic sb, logic eb, logic cr, logic par,
                                          logic [31:0] frac, logic hit);
        t_res_item r;
        r.start_behind = sb;
        r.end_behind   = eb;
        r.crossed      = cr;
        r.parallel     = par;
        r.fraction     = frac;
        r.hit          = hit;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        t_dir_row row;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.data  = data;
        row.seg   = '0;
        row.typed = 1'b0;
        row.res   = '0;
        return row;
    endfunction

    function automatic t_dir_row seg_row(logic [31:0] x1, logic [31:0] y1,
                                         logic [31:0] x2, logic [31:0] y2,
                                         logic typed = 1'b0, t_res_item res = '0);
        t_dir_row row;
        row.kind            = ROW_SEG;
        row.idx             = '0;
        row.data            = '0;
        row.seg.seg_start_x = x1;
        row.seg.seg_start_y = y1;
        row.seg.seg_end_x   = x2;
        row.seg.seg_end_y   = y2;
        row.typed           = typed;
        row.res             = res;
        return row;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ORIGIN_X: trace_ox = data;
            CFG_ORIGIN_Y: trace_oy = data;
            CFG_DELTA_X:  trace_dx = data;
            CFG_DELTA_Y:  trace_dy = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // called on a falling edge, returns on a falling edge
    task automatic send_seg(t_seg_item it, t_res_item want);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        expected_results.push_back(want);
        @(negedge clk);
    endtask

    task automatic load_trace(int mode);
        logic [31:0] ox, oy, dx, dy;
        ox = rand_fix();
        oy = rand_fix();
        dx = rand_fix();
        dy = rand_fix();
        case (mode)
            1: begin
                dy = '0;
                if (dx == '0)
                    dx = 32'h0001_0000;
            end
            2: dx = '0;
            3: begin
                ox = $urandom_range(0, 1) ? FRAC_MIN : FRAC_MAX;
                oy = $urandom_range(0, 1) ? FRAC_MIN : FRAC_MAX;
                dx = $urandom_range(0, 1) ? FRAC_MIN : FRAC_MAX;
                dy = $urandom_range(0, 1) ? FRAC_MIN : FRAC_MAX;
            end
            4: begin
                ox = $urandom;
                oy = $urandom;
                dx = $urandom;
                dy = $urandom;
            end
            5: begin
                dx = '0;
                dy = '0;
            end
            default: ;
        endcase
        cfg_write(CFG_ORIGIN_X, ox);
        cfg_write(CFG_ORIGIN_Y, oy);
        cfg_write(CFG_DELTA_X, dx);
        cfg_write(CFG_DELTA_Y, dy);
        cfg_write(CFG_FIRST_UNUSED + 3'($urandom_range(0, 3)), $urandom);
    endtask

    task automatic report_failure(string msg);
        if (fail_count < MAX_REPORTS)
            $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    // ---------------- result checker ----------------

    always @(posedge clk) begin
        t_res_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_failure($sformatf("unexpected result: sb=%b eb=%b cr=%b par=%b frac=%h hit=%b",
                    out_item.start_behind, out_item.end_behind, out_item.crossed,
                    out_item.parallel, out_item.fraction, out_item.hit));
            end else begin
                want = expected_results.pop_front();
                if (out_item.start_behind !== want.start_behind ||
                    out_item.end_behind !== want.end_behind ||
                    out_item.crossed !== want.crossed ||
                    out_item.parallel !== want.parallel ||
                    out_item.fraction !== want.fraction ||
                    out_item.hit !== want.hit) begin
                    report_failure($sformatf({"mismatch: exp sb=%b eb=%b cr=%b par=%b frac=%h hit=%b",
                        " / got sb=%b eb=%b cr=%b par=%b frac=%h hit=%b"},
                        want.start_behind, want.end_behind, want.crossed,
                        want.parallel, want.fraction, want.hit,
                        out_item.start_behind, out_item.end_behind, out_item.crossed,
                        out_item.parallel, out_item.fraction, out_item.hit));
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        t_seg_item seg;

        // reset state: zero direction, every endpoint in front
        dir_rows.push_back(seg_row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   1'b1, '0));
        dir_rows.push_back(seg_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                   1'b1, '0));
        dir_rows.push_back(seg_row(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1, 1'b1, '0));

        // horizontal trace along +x
        dir_rows.push_back(cfg_row(CFG_DELTA_X, 32'h0001_0000));
        // crossed with a zero denominator
        dir_rows.push_back(seg_row(32'h0, 32'h0, 32'h0, 32'h1,
                                   1'b1, res_val(1'b0, 1'b1, 1'b1, 1'b1, 32'h0, 1'b1)));
        // divide overflow, both signs
        dir_rows.push_back(seg_row(32'h7FFF_0000, 32'hFFFF_FF80, 32'h7FFF_0000, 32'h80,
                                   1'b1, res_val(1'b0, 1'b1, 1'b1, 1'b0, FRAC_MAX, 1'b1)));
        dir_rows.push_back(seg_row(32'h8000_0000, 32'hFFFF_FF80, 32'h8000_0000, 32'h80,
                                   1'b1, res_val(1'b0, 1'b1, 1'b1, 1'b0, FRAC_MIN, 1'b0)));
        dir_rows.push_back(seg_row(32'h0001_0000, 32'hFFFF_0000, 32'h0003_0000, 32'h0001_0000));
        dir_rows.push_back(seg_row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));

        // vertical trace at x = 0x5000
        dir_rows.push_back(cfg_row(CFG_DELTA_X, 32'h0));
        dir_rows.push_back(cfg_row(CFG_DELTA_Y, 32'h0001_0000));
        dir_rows.push_back(cfg_row(CFG_ORIGIN_X, 32'h5000));
        dir_rows.push_back(seg_row(32'h4000, 32'h0, 32'h6000, 32'h0001_0000));
        dir_rows.push_back(seg_row(32'h5000, 32'h0, 32'h5001, 32'h0));
        dir_rows.push_back(seg_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));

        // zero direction again, origin off zero
        dir_rows.push_back(cfg_row(CFG_DELTA_Y, 32'h0));
        dir_rows.push_back(seg_row(32'h4000, 32'h0, 32'h6000, 32'h0));

        // writes past the last register must not land anywhere
        dir_rows.push_back(cfg_row(CFG_FIRST_UNUSED, 32'hDEAD_BEEF));
        dir_rows.push_back(cfg_row(CFG_LAST_UNUSED, 32'h1234_5678));
        dir_rows.push_back(seg_row(32'h4000, 32'h0, 32'h6000, 32'h0));

        // oblique trace: sign shortcut and product compare
        dir_rows.push_back(cfg_row(CFG_ORIGIN_X, 32'hFFFE_0000));
        dir_rows.push_back(cfg_row(CFG_ORIGIN_Y, 32'h0003_0000));
        dir_rows.push_back(cfg_row(CFG_DELTA_X, 32'h0003_0000));
        dir_rows.push_back(cfg_row(CFG_DELTA_Y, 32'hFFFE_0000));
        dir_rows.push_back(seg_row(32'h0, 32'h0, 32'h0004_0000, 32'h0006_0000));
        dir_rows.push_back(seg_row(32'hFFFF_0000, 32'h0005_0000, 32'h0002_0000, 32'hFFFF_0000));
        dir_rows.push_back(seg_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        dir_rows.push_back(seg_row(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        dir_rows.push_back(seg_row(32'hFFFE_0000, 32'h0003_0000, 32'h0, 32'h0));

        // extreme trace registers
        dir_rows.push_back(cfg_row(CFG_ORIGIN_X, FRAC_MIN));
        dir_rows.push_back(cfg_row(CFG_ORIGIN_Y, FRAC_MAX));
        dir_rows.push_back(cfg_row(CFG_DELTA_X, FRAC_MAX));
        dir_rows.push_back(cfg_row(CFG_DELTA_Y, FRAC_MIN));
        dir_rows.push_back(seg_row(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000));
        dir_rows.push_back(seg_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
        dir_rows.push_back(seg_row(32'h1234_5678, 32'h9ABC_DEF0, 32'hFEDC_BA98, 32'h0123_4567));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_seg(dir_rows[i].seg, dir_rows[i].typed ? dir_rows[i].res
                                                            : predict_intercept(dir_rows[i].seg));
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            load_trace(ph % 6);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 74; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 74; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                seg = rand_segment();
                send_seg(seg, predict_intercept(seg));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
